### rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the background subtraction pixel core.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // frame size and store addressing
  localparam int unsigned PIXELS = 65536;
  localparam int unsigned ADDR_W = $clog2(PIXELS);

  // field widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CHANS   = 3;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned ALPHA_W = 9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [CHAN_W-1:0]  THRESHOLD_RST = 8'd30;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd0;
  localparam logic [COUNT_W-1:0] GHOST_RST     = 16'd0;

  // alpha of one in Q1.8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD   = 3'd0,
    CFG_BLEND_ALPHA_Q8   = 3'd1,
    CFG_SELECTIVE_UPDATE = 3'd2,
    CFG_GHOST_FRAMES     = 3'd3,
    CFG_COLOR_MODE       = 3'd4
  } cfg_reg_e;

  // request modes
  typedef enum logic {
    MODE_INIT     = 1'b0,
    MODE_SUBTRACT = 1'b1
  } pix_mode_e;

  // color modes
  typedef enum logic {
    COLOR_GREY = 1'b0,
    COLOR_RGB  = 1'b1
  } color_mode_e;

endpackage

### rtl/bsp_if.sv
// ----------------------------------------------------------------------------
// bsp_if
// Request and response channels of the background subtraction pixel core.
// ----------------------------------------------------------------------------

// pixel request channel
interface bsp_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [15:0] pixel_index;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;

  modport source (output valid, mode, pixel_index, chan_a, chan_b, chan_c,
                  input ready);
  modport sink   (input valid, mode, pixel_index, chan_a, chan_b, chan_c,
                  output ready);
endinterface

// classification response channel
interface bsp_rsp_if;
  logic        valid;
  logic        ready;
  logic        foreground;
  logic        ghost_reset;
  logic [15:0] out_index;

  modport source (output valid, foreground, ghost_reset, out_index,
                  input ready);
  modport sink   (input valid, foreground, ghost_reset, out_index,
                  output ready);
endinterface

### rtl/background_subtraction_pixel_core.sv
// ----------------------------------------------------------------------------
// background_subtraction_pixel_core
// Running-average background subtraction with ghost suppression, one pixel
// per request, background and foreground run count held in on-chip memory.
// ----------------------------------------------------------------------------
// The core takes one pixel request per clock while the response side keeps
// up, and returns one response per request, in order. Taking a request reads
// the background word and the run count of the pixel from two synchronous
// memories; the second stage then classifies, blends and writes both back
// while the response goes to the output register. The last write is kept in
// a bypass register, so requests that hit the same pixel back to back see
// the freshly written values and the rate stays at one pixel per cycle while
// the response side keeps up. The stores are not cleared: every pixel must
// get an init request before its first subtract request. Configuration must
// only be written while no request is in flight.
module background_subtraction_pixel_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bsp_req_if.sink                       req_i,
  bsp_rsp_if.source                     rsp_o
);
  import bsp_pkg::*;

  // configuration registers
  logic [CHAN_W-1:0]  thresh_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic               selective_q;
  logic [COUNT_W-1:0] ghost_frames_q;
  logic               color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q       <= THRESHOLD_RST;
      alpha_q        <= ALPHA_RST;
      selective_q    <= 1'b0;
      ghost_frames_q <= GHOST_RST;
      color_q        <= COLOR_GREY;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DIFF_THRESHOLD:   thresh_q       <= cfg_wdata_i[CHAN_W-1:0];
        CFG_BLEND_ALPHA_Q8:   alpha_q        <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_SELECTIVE_UPDATE: selective_q    <= cfg_wdata_i[0];
        CFG_GHOST_FRAMES:     ghost_frames_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_COLOR_MODE:       color_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic req_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic rsp_valid_q;

  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  // request address
  logic              req_in_range;
  logic [ADDR_W-1:0] req_addr;

  assign req_in_range = 32'(req_i.pixel_index) < PIXELS;
  assign req_addr     = req_i.pixel_index[ADDR_W-1:0];

  // stores
  logic [CHANS*CHAN_W-1:0] bg_mem  [PIXELS];
  logic [COUNT_W-1:0]      cnt_mem [PIXELS];

  logic [CHANS*CHAN_W-1:0] bg_rd_q;
  logic [COUNT_W-1:0]      cnt_rd_q;
  logic                    mem_we;
  logic [ADDR_W-1:0]       s1_addr_q;
  logic [CHANS*CHAN_W-1:0] bg_wr;
  logic [COUNT_W-1:0]      cnt_wr;

  // read port, sampled once per request
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      bg_rd_q  <= bg_mem[req_addr];
      cnt_rd_q <= cnt_mem[req_addr];
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bg_mem[s1_addr_q]  <= bg_wr;
      cnt_mem[s1_addr_q] <= cnt_wr;
    end
  end

  // second stage request registers
  logic                         s1_mode_q;
  logic                         s1_in_range_q;
  logic [INDEX_W-1:0]           s1_index_q;
  logic [CHANS-1:0][CHAN_W-1:0] s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_mode_q     <= req_i.mode;
      s1_in_range_q <= req_in_range;
      s1_index_q    <= req_i.pixel_index;
      s1_addr_q     <= req_addr;
      s1_pix_q      <= {req_i.chan_c, req_i.chan_b, req_i.chan_a};
    end
  end

  // bypass of the last write
  logic                    fwd_valid_q;
  logic [ADDR_W-1:0]       fwd_addr_q;
  logic [CHANS*CHAN_W-1:0] fwd_bg_q;
  logic [COUNT_W-1:0]      fwd_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_bg_q   <= bg_wr;
      fwd_cnt_q  <= cnt_wr;
    end
  end

  logic                         fwd_hit;
  logic [CHANS-1:0][CHAN_W-1:0] bg_cur;
  logic [COUNT_W-1:0]           cnt_cur;

  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_addr_q);
  assign bg_cur  = fwd_hit ? fwd_bg_q  : bg_rd_q;
  assign cnt_cur = fwd_hit ? fwd_cnt_q : cnt_rd_q;

  // per-channel compare and blend lanes
  logic [ALPHA_W-1:0]           alpha_sat;
  logic [CHANS-1:0]             lane_used;
  logic [CHANS-1:0]             lane_over;
  logic [CHAN_W-1:0]            abs_d   [CHANS];
  logic signed [CHAN_W:0]       diff_s  [CHANS];
  logic signed [18:0]           prod_s  [CHANS];
  logic [18:0]                  rnd     [CHANS];
  logic [10:0]                  sum_b   [CHANS];
  logic [CHANS-1:0][CHAN_W-1:0] blend_v;

  assign alpha_sat = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;

  always_comb begin
    for (int k = 0; k < CHANS; k++) begin
      lane_used[k] = (k == 0) || (color_q == COLOR_RGB);
      abs_d[k]     = (s1_pix_q[k] > bg_cur[k]) ? s1_pix_q[k] - bg_cur[k]
                                               : bg_cur[k] - s1_pix_q[k];
      lane_over[k] = lane_used[k] && (abs_d[k] > thresh_q);
      diff_s[k]    = $signed({1'b0, s1_pix_q[k]}) - $signed({1'b0, bg_cur[k]});
      prod_s[k]    = 19'(diff_s[k]) * 19'($signed({1'b0, alpha_sat}));
      rnd[k]       = 19'(prod_s[k]) + 19'd128;
      sum_b[k]     = {3'b000, bg_cur[k]} + rnd[k][18:8];
      blend_v[k]   = sum_b[k][CHAN_W-1:0];
    end
  end

  // classification, ghost counter and write-back data
  logic                         is_sub;
  logic                         fg;
  logic                         ghost_en;
  logic [COUNT_W-1:0]           cnt_inc;
  logic                         force_bg;
  logic                         blend_on;
  logic [CHANS-1:0][CHAN_W-1:0] bg_new;

  assign is_sub   = s1_in_range_q && (s1_mode_q == MODE_SUBTRACT);
  assign fg       = is_sub && (|lane_over);
  assign ghost_en = ghost_frames_q != '0;
  assign cnt_inc  = fg ? cnt_cur + COUNT_W'(1) : '0;
  assign force_bg = is_sub && ghost_en && (cnt_inc >= ghost_frames_q);
  assign blend_on = !selective_q || !fg;

  always_comb begin
    for (int k = 0; k < CHANS; k++) begin
      if (s1_mode_q == MODE_INIT) begin
        bg_new[k] = s1_pix_q[k];
      end else if (!lane_used[k]) begin
        bg_new[k] = bg_cur[k];
      end else if (force_bg) begin
        bg_new[k] = s1_pix_q[k];
      end else if (blend_on) begin
        bg_new[k] = blend_v[k];
      end else begin
        bg_new[k] = bg_cur[k];
      end
    end
  end

  always_comb begin
    priority if (s1_mode_q == MODE_INIT) begin
      cnt_wr = '0;
    end else if (!ghost_en) begin
      cnt_wr = cnt_cur;
    end else if (force_bg) begin
      cnt_wr = '0;
    end else begin
      cnt_wr = cnt_inc;
    end
  end

  assign bg_wr  = bg_new;
  assign mem_we = s1_adv && s1_in_range_q;

  // response register
  logic               rsp_fg_q;
  logic               rsp_ghost_q;
  logic [INDEX_W-1:0] rsp_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_fg_q    <= fg;
      rsp_ghost_q <= force_bg;
      rsp_index_q <= s1_index_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.foreground  = rsp_fg_q;
  assign rsp_o.ghost_reset = rsp_ghost_q;
  assign rsp_o.out_index   = rsp_index_q;

  // checks
  a_no_write_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && rsp_valid_q && !rsp_o.ready) |-> !mem_we)
    else $error("store written while the response register is stalled");

  a_req_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> s1_valid_q)
    else $error("accepted request missing from the second stage");

  a_ghost_needs_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_ghost_q) |-> rsp_fg_q)
    else $error("ghost reset reported on a background pixel");

  a_bypass_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (fwd_valid_q && (fwd_addr_q == $past(s1_addr_q))))
    else $error("bypass register not loaded with the last write");

endmodule

### bench/background_subtraction_pixel_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_subtraction_pixel_core_test
// Self-checking bench for the background subtraction pixel core. Pixel
// requests go in through a request queue with random sender gaps and
// receiver stalls. Each accepted request runs through a bench-side model of
// the background store, the run counters and the registers. Every response
// is compared field by field with the oldest predicted verdict. Registers
// are only rewritten while the core is idle.
// ----------------------------------------------------------------------------
module background_subtraction_pixel_core_test;
  import bsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOT_PIXELS  = 24;
  // register index past the end of the map, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    pix_mode_e           mode;
    logic [INDEX_W-1:0]  index;
    logic [CHAN_W-1:0]   chan_a;
    logic [CHAN_W-1:0]   chan_b;
    logic [CHAN_W-1:0]   chan_c;
  } pixel_req_t;

  typedef struct packed {
    logic               foreground;
    logic               ghost_reset;
    logic [INDEX_W-1:0] out_index;
  } verdict_t;

  // clock, reset and configuration port
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // channel drive registers
  pixel_req_t req_q       = '0;
  logic       req_valid_q = 1'b0;
  logic       rsp_ready_q = 1'b0;

  bsp_req_if req_if ();
  bsp_rsp_if rsp_if ();

  assign req_if.valid       = req_valid_q;
  assign req_if.mode        = req_q.mode;
  assign req_if.pixel_index = req_q.index;
  assign req_if.chan_a      = req_q.chan_a;
  assign req_if.chan_b      = req_q.chan_b;
  assign req_if.chan_c      = req_q.chan_c;
  assign rsp_if.ready       = rsp_ready_q;

  background_subtraction_pixel_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // register copies
  logic [CHAN_W-1:0]  diff_limit  = THRESHOLD_RST;
  logic [ALPHA_W-1:0] learn_rate  = ALPHA_RST;
  logic               selective   = 1'b0;
  logic [COUNT_W-1:0] ghost_limit = GHOST_RST;
  color_mode_e        color_sel   = COLOR_GREY;

  // model of the stores, plus the last init value the stimulus knows of
  logic [23:0]        bg_store  [PIXELS];
  logic [COUNT_W-1:0] run_store [PIXELS];
  logic [23:0]        scene     [PIXELS];

  pixel_req_t         pixel_backlog[$];
  verdict_t           expected_verdicts[$];
  logic [INDEX_W-1:0] hot_pixels[$];
  logic [INDEX_W-1:0] last_index = '0;

  verdict_t due_verdict;
  int  cycles     = 0;
  int  mismatches = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  bit  req_sent   = 1'b0;
  bit  calm       = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // classify one pixel and update the stores and run counters
  function automatic verdict_t classify_pixel(input pixel_req_t px);
    verdict_t           v;
    logic [23:0]        pix_word;
    logic [23:0]        bg;
    logic [23:0]        nb;
    logic [ALPHA_W-1:0] a;
    logic [CHAN_W-1:0]  p;
    logic [CHAN_W-1:0]  b;
    logic [CHAN_W-1:0]  d;
    logic [COUNT_W-1:0] cnt;
    int                 nch;
    int                 mix;
    v           = '0;
    v.out_index = px.index;
    pix_word    = {px.chan_c, px.chan_b, px.chan_a};
    if (px.mode == MODE_INIT) begin
      bg_store[px.index]  = pix_word;
      run_store[px.index] = '0;
      return v;
    end
    nch = (color_sel == COLOR_RGB) ? 3 : 1;
    bg  = bg_store[px.index];
    nb  = bg;
    a   = (learn_rate > ALPHA_ONE) ? ALPHA_ONE : learn_rate;
    for (int k = 0; k < nch; k++) begin
      p = pix_word[8*k +: 8];
      b = bg[8*k +: 8];
      d = (p > b) ? p - b : b - p;
      if (d > diff_limit) v.foreground = 1'b1;
    end
    // running average, rounded half up
    if (!selective || !v.foreground) begin
      for (int k = 0; k < nch; k++) begin
        mix = (int'(pix_word[8*k +: 8]) * int'(a)
               + int'(bg[8*k +: 8]) * (256 - int'(a)) + 128) >> 8;
        nb[8*k +: 8] = mix[7:0];
      end
    end
    // ghost suppression on long foreground runs
    if (ghost_limit != '0) begin
      cnt = v.foreground ? run_store[px.index] + 16'd1 : '0;
      if (cnt >= ghost_limit) begin
        for (int k = 0; k < nch; k++) nb[8*k +: 8] = pix_word[8*k +: 8];
        cnt           = '0;
        v.ghost_reset = 1'b1;
      end
      run_store[px.index] = cnt;
    end
    bg_store[px.index] = nb;
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("[%0t] pixel verdict mismatch on %s: got %0d, expected %0d",
             $realtime, what, got, want);
    mismatches++;
  endtask

  // request sampling, prediction and response checking
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (req_if.valid && req_if.ready) begin
      expected_verdicts.push_back(classify_pixel(req_q));
      void'(pixel_backlog.pop_front());
      req_sent = 1'b1;
    end
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch("unexpected response, index", rsp_if.out_index, 16'd0);
      end else begin
        due_verdict = expected_verdicts.pop_front();
        if (rsp_if.foreground !== due_verdict.foreground)
          note_mismatch("foreground", 16'(rsp_if.foreground),
                        16'(due_verdict.foreground));
        if (rsp_if.ghost_reset !== due_verdict.ghost_reset)
          note_mismatch("ghost_reset", 16'(rsp_if.ghost_reset),
                        16'(due_verdict.ghost_reset));
        if (rsp_if.out_index !== due_verdict.out_index)
          note_mismatch("out_index", rsp_if.out_index, due_verdict.out_index);
      end
    end
  end

  // request driver with random gaps between requests
  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid_q || req_sent)) begin
      req_sent = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_valid_q <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        req_q       <= pixel_backlog[0];
        req_valid_q <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 7);
      end else begin
        req_valid_q <= 1'b0;
      end
    end
  end

  // response ready with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready_q <= 1'b0;
    end else begin
      rsp_ready_q <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  task automatic queue_pixel(input pix_mode_e mode, input logic [15:0] idx,
                             input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c);
    pixel_req_t px;
    px.mode   = mode;
    px.index  = idx;
    px.chan_a = a;
    px.chan_b = b;
    px.chan_c = c;
    if (mode == MODE_INIT) scene[idx] = {c, b, a};
    pixel_backlog.push_back(px);
  endtask

  task automatic settle();
    while (pixel_backlog.size() != 0 || expected_verdicts.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (which)
      CFG_DIFF_THRESHOLD:   diff_limit  = data[7:0];
      CFG_BLEND_ALPHA_Q8:   learn_rate  = data[8:0];
      CFG_SELECTIVE_UPDATE: selective   = data[0];
      CFG_GHOST_FRAMES:     ghost_limit = data;
      CFG_COLOR_MODE:       color_sel   = color_mode_e'(data[0]);
      default: ;
    endcase
  endtask

  // full register set, unused upper data bits filled with junk
  task automatic configure(input logic [7:0] thr, input logic [8:0] alpha,
                           input logic sel, input logic [15:0] ghost,
                           input color_mode_e color);
    write_reg(CFG_DIFF_THRESHOLD, {8'($urandom), thr});
    write_reg(CFG_BLEND_ALPHA_Q8, {7'($urandom), alpha});
    write_reg(CFG_SELECTIVE_UPDATE, {15'($urandom), sel});
    write_reg(CFG_GHOST_FRAMES, ghost);
    write_reg(CFG_COLOR_MODE, {15'($urandom), color});
  endtask

  function automatic logic [7:0] jitter(input logic [7:0] base, input int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // random traffic, mostly subtracts on a small set of initialized pixels
  task automatic stream_pixels(input int count);
    logic [15:0] idx;
    logic [23:0] base;
    int          n;
    int          streak;
    int          spread;
    int          choice;
    n = 0;
    if (hot_pixels.size() == 0) begin
      for (int i = 0; i < HOT_PIXELS; i++) begin
        idx = (i < 8) ? 16'(i + 300) : 16'($urandom);
        queue_pixel(MODE_INIT, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        hot_pixels.push_back(idx);
      end
      last_index = hot_pixels[0];
    end
    while (n < count) begin
      choice = $urandom_range(0, 19);
      if (choice < 2) begin
        // fresh pixel anywhere in the frame
        idx = 16'($urandom);
        queue_pixel(MODE_INIT, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        hot_pixels[$urandom_range(0, HOT_PIXELS - 1)] = idx;
        last_index = idx;
        n++;
      end else if (choice < 4) begin
        // run of foreground frames on one pixel
        idx    = hot_pixels[$urandom_range(0, HOT_PIXELS - 1)];
        base   = ~scene[idx];
        streak = $urandom_range(2, 6);
        repeat (streak) begin
          queue_pixel(MODE_SUBTRACT, idx, jitter(base[7:0], 16),
                      jitter(base[15:8], 16), jitter(base[23:16], 16));
        end
        last_index = idx;
        n += streak;
      end else if (choice == 4) begin
        // re-init of a busy pixel
        idx = hot_pixels[$urandom_range(0, HOT_PIXELS - 1)];
        queue_pixel(MODE_INIT, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        last_index = idx;
        n++;
      end else begin
        if ($urandom_range(0, 2) != 0) idx = hot_pixels[$urandom_range(0, HOT_PIXELS - 1)];
        else idx = last_index;
        case ($urandom_range(0, 3))
          0: spread = 3;
          1: spread = 24;
          2: spread = 60;
          default: spread = 255;
        endcase
        base = scene[idx];
        queue_pixel(MODE_SUBTRACT, idx, jitter(base[7:0], spread),
                    jitter(base[15:8], spread), jitter(base[23:16], spread));
        last_index = idx;
        n++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: grey, threshold 30, no learning, no ghost check
    queue_pixel(MODE_INIT, 16'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(MODE_INIT, 16'hFFFF, 8'd255, 8'd255, 8'd255);
    queue_pixel(MODE_SUBTRACT, 16'd0, 8'd31, 8'd255, 8'd255);
    queue_pixel(MODE_SUBTRACT, 16'd0, 8'd30, 8'd0, 8'd0);
    queue_pixel(MODE_SUBTRACT, 16'hFFFF, 8'd255, 8'd0, 8'd0);
    queue_pixel(MODE_SUBTRACT, 16'hFFFF, 8'd224, 8'd255, 8'd255);
    settle();

    // zero threshold, saturated alpha, ghost after two frames
    configure(8'd0, 9'h1FF, 1'b0, 16'd2, COLOR_RGB);
    queue_pixel(MODE_INIT, 16'd1, 8'd10, 8'd20, 8'd30);
    queue_pixel(MODE_SUBTRACT, 16'd1, 8'd10, 8'd20, 8'd31);
    queue_pixel(MODE_SUBTRACT, 16'd1, 8'd10, 8'd20, 8'd32);
    queue_pixel(MODE_SUBTRACT, 16'd1, 8'd10, 8'd20, 8'd32);
    queue_pixel(MODE_SUBTRACT, 16'hFFFF, 8'd255, 8'd255, 8'd255);
    settle();

    // max threshold, half alpha rounding, selective, unreachable ghost limit
    configure(8'd255, 9'd128, 1'b1, 16'hFFFF, COLOR_RGB);
    write_reg(CFG_SPARE, 16'hFFFF);
    queue_pixel(MODE_INIT, 16'd2, 8'd0, 8'd255, 8'd128);
    queue_pixel(MODE_SUBTRACT, 16'd2, 8'd255, 8'd0, 8'd129);
    queue_pixel(MODE_SUBTRACT, 16'd2, 8'd1, 8'd0, 8'd0);
    settle();

    // selective grey: foreground skips the blend, background takes it
    configure(8'd0, 9'd128, 1'b1, 16'd0, COLOR_GREY);
    queue_pixel(MODE_SUBTRACT, 16'd2, 8'd0, 8'd17, 8'd99);
    queue_pixel(MODE_SUBTRACT, 16'd2, 8'd64, 8'd0, 8'd0);
    queue_pixel(MODE_SUBTRACT, 16'd2, 8'd64, 8'd255, 8'd255);
    settle();

    configure(8'd30, 9'd64, 1'b0, 16'd0, COLOR_RGB);
    stream_pixels(200);
    settle();
    configure(8'd0, 9'd256, 1'b1, 16'd1, COLOR_GREY);
    stream_pixels(150);
    settle();
    configure(8'd255, 9'd0, 1'b0, 16'hFFFF, COLOR_RGB);
    stream_pixels(150);
    settle();
    configure(8'd20, 9'h1FF, 1'b1, 16'd3, COLOR_RGB);
    stream_pixels(200);
    settle();
    repeat (3) begin
      configure(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                1'($urandom_range(0, 1)), 16'($urandom_range(0, 5)),
                color_mode_e'($urandom_range(0, 1)));
      stream_pixels(150);
      settle();
    end

    // closing stretch at full rate on both sides
    configure(8'd12, 9'd200, 1'b0, 16'd2, COLOR_RGB);
    calm = 1'b1;
    stream_pixels(250);
    settle();
    repeat (16) @(posedge clk_i);

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
